FILE: src/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types, constants and helpers for the ordered list block.
// ----------------------------------------------------------------------------
`default_nettype none

package olid_pkg;

    // list geometry
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);

    // request and result field widths
    localparam int TYPE_W = 2;
    localparam int POS_W  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 8;

    // request type codes
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_READ   = 2'd2;

    // operation handed to the shift engine
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_READ
    } olid_op_t;

    // command from the control to the shift engine
    typedef struct packed {
        logic              start;
        olid_op_t          op;
        logic [ADDR_W-1:0] pos;
        logic [ADDR_W-1:0] last;
        logic [DATA_W-1:0] value;
    } olid_cmd_t;

    // status back from the shift engine
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rdata;
    } olid_sts_t;

    // clamp a signed position into 0..top
    function automatic logic [ADDR_W-1:0] clamp_pos(
        input logic signed [POS_W-1:0] pos,
        input logic        [ADDR_W-1:0] top
    );
        logic signed [POS_W-1:0] top_s;
        logic        [ADDR_W-1:0] res;
        top_s = POS_W'(top);
        priority if (pos < 0)
            res = '0;
        else if (pos > top_s)
            res = top;
        else
            res = pos[ADDR_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/olid_req_if.sv
// ----------------------------------------------------------------------------
// olid_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface olid_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [olid_pkg::TYPE_W-1:0]          req_type;
    logic signed [olid_pkg::POS_W-1:0]    position;
    logic signed [olid_pkg::DATA_W-1:0]   new_value;

    modport source (output valid, output req_type, output position, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input new_value,
                    output ready);
endinterface

`default_nettype wire

FILE: src/olid_rsp_if.sv
// ----------------------------------------------------------------------------
// olid_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface olid_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [olid_pkg::CNT_W-1:0]           entry_count;
    logic signed [olid_pkg::DATA_W-1:0]   read_value;
    logic                                 dropped_last;

    modport source (output valid, output entry_count, output read_value,
                    output dropped_last, input ready);
    modport sink   (input valid, input entry_count, input read_value,
                    input dropped_last, output ready);
endinterface

`default_nettype wire

FILE: src/olid_shift_engine.sv
// ----------------------------------------------------------------------------
// olid_shift_engine
// Entry memory with a read/modify/write sequencer that shifts entries one
// place per cycle for insert and delete, and reads a single entry.
// ----------------------------------------------------------------------------
`default_nettype none

module olid_shift_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire olid_pkg::olid_cmd_t cmd,
    output olid_pkg::olid_sts_t      sts
);

    typedef enum logic [2:0] {
        E_IDLE  = 3'b001,
        E_SHIFT = 3'b010,
        E_READ  = 3'b100
    } eng_state_t;

    eng_state_t                       state_reg, state_next;
    olid_pkg::olid_op_t               op_reg, op_next;
    logic [olid_pkg::ADDR_W-1:0]      idx_reg, idx_next;
    logic [olid_pkg::ADDR_W-1:0]      end_reg, end_next;
    logic [olid_pkg::DATA_W-1:0]      value_reg, value_next;
    logic                             pend_reg, pend_next;
    logic [olid_pkg::ADDR_W-1:0]      pend_addr_reg, pend_addr_next;

    // memory ports
    logic [olid_pkg::DATA_W-1:0]      mem [olid_pkg::CAPACITY];
    logic [olid_pkg::DATA_W-1:0]      rdata_reg;
    logic                             re;
    logic [olid_pkg::ADDR_W-1:0]      raddr;
    logic                             we;
    logic [olid_pkg::ADDR_W-1:0]      waddr;
    logic [olid_pkg::DATA_W-1:0]      wdata;
    logic                             done;

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // sequencer; a shift always reads toward the far end of the moved range
    // while writing behind it, so read and write never hit the same entry
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        value_next     = value_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        re             = 1'b0;
        raddr          = idx_reg;
        we             = 1'b0;
        waddr          = pend_addr_reg;
        wdata          = rdata_reg;
        done           = 1'b0;

        unique case (state_reg)
            E_IDLE:
            begin
                if (cmd.start)
                begin
                    op_next    = cmd.op;
                    value_next = cmd.value;
                    pend_next  = 1'b0;
                    if (cmd.op == olid_pkg::OP_INSERT)
                    begin
                        idx_next = cmd.last;
                        end_next = cmd.pos;
                    end
                    else
                    begin
                        idx_next = cmd.pos;
                        end_next = cmd.last;
                    end
                    if (cmd.op == olid_pkg::OP_READ)
                    begin
                        re         = 1'b1;
                        raddr      = cmd.pos;
                        state_next = E_READ;
                    end
                    else
                    begin
                        state_next = E_SHIFT;
                    end
                end
            end

            E_READ:
            begin
                done       = 1'b1;
                state_next = E_IDLE;
            end

            E_SHIFT:
            begin
                // write back the entry fetched last cycle
                if (pend_reg)
                begin
                    we = 1'b1;
                end
                pend_next = 1'b0;
                if (idx_reg != end_reg)
                begin
                    re             = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    if (op_reg == olid_pkg::OP_INSERT)
                    begin
                        raddr    = idx_reg - olid_pkg::ADDR_W'(1);
                        idx_next = idx_reg - olid_pkg::ADDR_W'(1);
                    end
                    else
                    begin
                        raddr    = idx_reg + olid_pkg::ADDR_W'(1);
                        idx_next = idx_reg + olid_pkg::ADDR_W'(1);
                    end
                end
                else if (!pend_reg)
                begin
                    // shift drained; insert stores the new value in the gap
                    if (op_reg == olid_pkg::OP_INSERT)
                    begin
                        we    = 1'b1;
                        waddr = end_reg;
                        wdata = value_reg;
                    end
                    done       = 1'b1;
                    state_next = E_IDLE;
                end
            end

            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        end_reg       <= end_next;
        value_reg     <= value_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign sts.done  = done;
    assign sts.rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of signed 32-bit entries with insert, delete and read requests.
// ----------------------------------------------------------------------------
// The list lives in a 128 x 32 single-port-write memory with a registered read,
// and every request returns one result carrying the new entry count. Requests
// are handled one at a time. A read fetches the entry at its clamped position.
// An insert at clamped position p moves the entries from p up to last - 1 one
// place up and stores the new value at p, where last is the count (or 127 when
// full); a delete at p moves the entries from p + 1 up to count - 1 one place
// down. The memory moves one entry per cycle through its single read and write
// port. Delete or read on an empty list and request type 3 skip the memory and
// return only the count. A result waiting on the output does not hold off the
// next request, but that request's result waits behind it, and each cycle of
// output stall adds to its time.
`default_nettype none

module ordered_list_insert_delete (
    input  wire logic   clk,
    input  wire logic   rst_n,
    olid_req_if.sink    req,
    olid_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_BUSY = 3'b010,
        T_OUT  = 3'b100
    } top_state_t;

    top_state_t                   state_reg, state_next;
    logic [olid_pkg::CNT_W-1:0]   count_reg, count_next;

    // pending result of the request in progress
    logic [olid_pkg::CNT_W-1:0]   res_count_reg, res_count_next;
    logic [olid_pkg::DATA_W-1:0]  res_value_reg, res_value_next;
    logic                         res_drop_reg, res_drop_next;
    logic                         res_read_reg, res_read_next;

    // output register
    logic                         rsp_valid_reg, rsp_valid_next;
    logic [olid_pkg::CNT_W-1:0]   out_count_reg, out_count_next;
    logic [olid_pkg::DATA_W-1:0]  out_value_reg, out_value_next;
    logic                         out_drop_reg, out_drop_next;

    olid_pkg::olid_cmd_t          cmd;
    olid_pkg::olid_sts_t          sts;

    logic                         accept;
    logic                         full;
    logic                         empty;
    logic [olid_pkg::CNT_W-1:0]   count_m1;
    logic [olid_pkg::ADDR_W-1:0]  ins_top;
    logic [olid_pkg::ADDR_W-1:0]  ins_last;
    logic [olid_pkg::ADDR_W-1:0]  tail_idx;
    logic                         load_out;

    assign req.ready = (state_reg == T_IDLE);
    assign accept    = req.valid && req.ready;

    // list bounds from the current count
    assign full     = (count_reg >= olid_pkg::CNT_W'(olid_pkg::CAPACITY));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - olid_pkg::CNT_W'(1);
    assign tail_idx = count_m1[olid_pkg::ADDR_W-1:0];
    assign ins_top  = (count_reg >= olid_pkg::CNT_W'(olid_pkg::CAPACITY - 1))
                      ? olid_pkg::ADDR_W'(olid_pkg::CAPACITY - 1)
                      : count_reg[olid_pkg::ADDR_W-1:0];
    assign ins_last = full ? olid_pkg::ADDR_W'(olid_pkg::CAPACITY - 1)
                           : count_reg[olid_pkg::ADDR_W-1:0];

    assign load_out = (state_reg == T_OUT) && (!rsp_valid_reg || rsp.ready);

    // request decode and control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_count_next = res_count_reg;
        res_value_next = res_value_reg;
        res_drop_next  = res_drop_reg;
        res_read_next  = res_read_reg;
        cmd.start      = 1'b0;
        cmd.op         = olid_pkg::OP_READ;
        cmd.pos        = olid_pkg::clamp_pos(req.position, tail_idx);
        cmd.last       = tail_idx;
        cmd.value      = req.new_value;

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    res_value_next = '0;
                    res_drop_next  = 1'b0;
                    res_read_next  = 1'b0;
                    state_next     = T_OUT;
                    unique case (req.req_type)
                        olid_pkg::REQ_INSERT:
                        begin
                            cmd.start     = 1'b1;
                            cmd.op        = olid_pkg::OP_INSERT;
                            cmd.pos       = olid_pkg::clamp_pos(req.position, ins_top);
                            cmd.last      = ins_last;
                            res_drop_next = full;
                            if (!full)
                            begin
                                count_next = count_reg + olid_pkg::CNT_W'(1);
                            end
                            state_next    = T_BUSY;
                        end
                        olid_pkg::REQ_DELETE:
                        begin
                            if (!empty)
                            begin
                                cmd.start  = 1'b1;
                                cmd.op     = olid_pkg::OP_DELETE;
                                count_next = count_m1;
                                state_next = T_BUSY;
                            end
                        end
                        olid_pkg::REQ_READ:
                        begin
                            if (!empty)
                            begin
                                cmd.start     = 1'b1;
                                cmd.op        = olid_pkg::OP_READ;
                                res_read_next = 1'b1;
                                state_next    = T_BUSY;
                            end
                        end
                        default:
                        begin
                            // unused code, count only
                        end
                    endcase
                    res_count_next = count_next;
                end
            end

            T_BUSY:
            begin
                if (sts.done)
                begin
                    if (res_read_reg)
                    begin
                        res_value_next = sts.rdata;
                    end
                    state_next = T_OUT;
                end
            end

            T_OUT:
            begin
                if (load_out)
                begin
                    state_next = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        out_count_next = out_count_reg;
        out_value_next = out_value_reg;
        out_drop_next  = out_drop_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
            out_count_next = res_count_reg;
            out_value_next = res_value_reg;
            out_drop_next  = res_drop_reg;
        end
    end

    olid_shift_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        res_count_reg <= res_count_next;
        res_value_reg <= res_value_next;
        res_drop_reg  <= res_drop_next;
        res_read_reg  <= res_read_next;
        out_count_reg <= out_count_next;
        out_value_reg <= out_value_next;
        out_drop_reg  <= out_drop_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.entry_count  = out_count_reg;
    assign rsp.read_value   = out_value_reg;
    assign rsp.dropped_last = out_drop_reg;

    // count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= olid_pkg::CNT_W'(olid_pkg::CAPACITY))
    else $error("entry count above capacity");

    // the engine only finishes while a request is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> (state_reg == T_BUSY))
    else $error("engine done outside a request");

    // a dropped entry is only reported with a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && out_drop_reg)
        |-> (out_count_reg == olid_pkg::CNT_W'(olid_pkg::CAPACITY)))
    else $error("drop flag with list not full");

    // a new result only appears after the request finished
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == T_OUT))
    else $error("result loaded outside the output state");

endmodule

`default_nettype wire
